FILE: sv/bounded_sorted_front_insert_unit_defines.svh
// Assertion macros for the bounded sorted front insert unit.
// Included by the top level; depends on nothing else.
`ifndef BOUNDED_SORTED_FRONT_INSERT_UNIT_DEFINES_SVH
`define BOUNDED_SORTED_FRONT_INSERT_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSFI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSFI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bsfi_pkg.sv
// Shared types and constants for the bounded sorted front insert unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsfi_pkg;

    localparam int TAG_W   = 16;
    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 4;
    localparam int FCNT_W  = 5;
    localparam int FSIZE_W = 5;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register word index, taken from paddr[2]
    localparam logic REG_FRONT_SIZE = 1'b0;

    localparam logic [FSIZE_W-1:0] FRONT_SIZE_RESET = 5'd16;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic wr_en;     // list update this cycle
        logic occupied;  // cell index below current count
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bounded_sorted_front_insert_unit.sv
// Bounded sorted front insert unit: top level, cell chain and APB register.
// Depends on bsfi_pkg, bsfi_cell and bounded_sorted_front_insert_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  - Input channel s_*: one word per offer, a tag and an unsigned Q16.16 key.
//  - Result channel m_*: one word per offer: added flag, insert slot,
//    count after the step, evict flag and evicted tag (zero when none).
//  - APB port: one register, front_size, at byte address 0 (bits [4:0]).
//    Writes at other word addresses are dropped. Write only while idle.
//  - Result: registered; it is valid in the cycle after the offer is accepted.
//  - Throughput: one offer per cycle unless a result stalls. All cells compare the offered key
//    in parallel and the chain shifts in the same cycle, so the list and
//    count are ready for the next offer at the following edge.
//  - Stall: a result waits in the output register; s_ready follows
//    m_ready while a result is pending, so nothing is lost or repeated.
//  - Reset: the list is empty (count 0), front_size is 16, no result pending.
//    Entry storage is not cleared; only entries below the count are read.
//  - Equal keys: the newest offer goes in front of older equal keys.
//  - A lowered front_size drops at most one entry per offer.

module bounded_sorted_front_insert_unit #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire  logic                            aclk,
    input  wire  logic                            aresetn,
    // input channel
    input  wire  logic                            s_valid,
    output       logic                            s_ready,
    input  wire  logic [bsfi_pkg::TAG_W-1:0]      s_item_tag,
    input  wire  logic [bsfi_pkg::KEY_W-1:0]      s_item_key,
    // result channel
    output       logic                            m_valid,
    input  wire  logic                            m_ready,
    output       logic                            m_was_added,
    output       logic [bsfi_pkg::SLOT_W-1:0]     m_insert_slot,
    output       logic [bsfi_pkg::FCNT_W-1:0]     m_front_count,
    output       logic                            m_evict_valid,
    output       logic [bsfi_pkg::TAG_W-1:0]      m_evict_tag,
    // configuration
    input  wire  logic                            psel,
    input  wire  logic                            penable,
    input  wire  logic                            pwrite,
    input  wire  logic [bsfi_pkg::PADDR_W-1:0]    paddr,
    input  wire  logic [bsfi_pkg::PDATA_W-1:0]    pwdata,
    output       logic [bsfi_pkg::PDATA_W-1:0]    prdata,
    output       logic                            pready
);

`include "bounded_sorted_front_insert_unit_defines.svh"

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    // compare width: room for count + 1 and for front_size
    localparam int CMP_W = ((CNT_W > bsfi_pkg::FSIZE_W) ? CNT_W : bsfi_pkg::FSIZE_W) + 1;

    // ---------------- configuration register ----------------
    logic [bsfi_pkg::FSIZE_W-1:0] front_size_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == bsfi_pkg::REG_FRONT_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_size_reg <= bsfi_pkg::FRONT_SIZE_RESET;
        end else if (cfg_wr) begin
            front_size_reg <= pwdata[bsfi_pkg::FSIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == bsfi_pkg::REG_FRONT_SIZE) begin
            prdata = bsfi_pkg::PDATA_W'(front_size_reg);
        end
    end

    // ---------------- handshake ----------------
    logic out_valid_reg;
    logic accept;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    // ---------------- cell chain ----------------
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    bsfi_pkg::entry_t     item;
    bsfi_pkg::entry_t     cell_entry [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_ge;
    logic [MAX_ENTRIES-1:0] occupied;
    logic [MAX_ENTRIES-1:0] first_ge;
    logic                 added;

    assign item.tag = s_item_tag;
    assign item.key = s_item_key;

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            occupied[i] = (CNT_W'(i) < cnt_reg);
        end
    end

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        bsfi_pkg::cell_ctrl_t ctrl;
        bsfi_pkg::entry_t     left_entry;
        logic                 left_ge;

        assign ctrl.wr_en    = accept && added;
        assign ctrl.occupied = occupied[gi];

        if (gi == 0) begin : g_head
            assign left_entry = item;
            assign left_ge    = 1'b0;
        end else begin : g_body
            assign left_entry = cell_entry[gi-1];
            assign left_ge    = cell_ge[gi-1];
        end

        bsfi_cell u_cell (
            .aclk       (aclk),
            .item       (item),
            .left_entry (left_entry),
            .left_ge    (left_ge),
            .ctrl       (ctrl),
            .held_entry (cell_entry[gi]),
            .ge         (cell_ge[gi])
        );

        // ge is monotone along the chain: insert point is its rising edge
        assign first_ge[gi] = cell_ge[gi] && !left_ge;
    end

    // ---------------- step decision ----------------
    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  cnt_ext;
    logic [CMP_W-1:0]  cnt_added;
    logic              found;
    logic              cnt_lt_limit;
    logic              evict;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt_m1;
    logic [IDX_W+bsfi_pkg::SLOT_W-1:0] pos_wide;
    logic [CNT_W+bsfi_pkg::FCNT_W-1:0] cnt_wide;

    assign cnt_ext = CMP_W'(cnt_reg);

    always_comb begin
        if (CMP_W'(front_size_reg) > CMP_W'(MAX_ENTRIES)) begin
            limit = CMP_W'(MAX_ENTRIES);
        end else begin
            limit = CMP_W'(front_size_reg);
        end
    end

    assign found        = |(cell_ge & occupied);
    assign cnt_lt_limit = (cnt_ext < limit);
    assign added        = found || cnt_lt_limit;
    assign cnt_added    = cnt_ext + CMP_W'(added);
    assign evict        = (cnt_added > limit) && (cnt_added != '0);
    assign cnt_next     = CNT_W'(cnt_added - CMP_W'(evict));

    always_comb begin
        pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (first_ge[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    // the dropped entry is always the last held one before the shift
    assign cnt_m1   = cnt_reg - CNT_W'(1);
    assign pos_wide = (IDX_W + bsfi_pkg::SLOT_W)'(pos);
    assign cnt_wide = (CNT_W + bsfi_pkg::FCNT_W)'(cnt_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, held while the receiver stalls
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_was_added   <= added;
            m_insert_slot <= added ? pos_wide[bsfi_pkg::SLOT_W-1:0] : '0;
            m_front_count <= cnt_wide[bsfi_pkg::FCNT_W-1:0];
            m_evict_valid <= evict;
            m_evict_tag   <= evict ? cell_entry[cnt_m1[IDX_W-1:0]].tag : '0;
        end
    end

    // ---------------- assertions ----------------
    `BSFI_ASSERT_NOW(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(MAX_ENTRIES), "count past depth")
    `BSFI_ASSERT_NEXT(a_result_follows, aclk, aresetn, accept, m_valid, "accepted word without result")
    `BSFI_ASSERT_NEXT(a_no_evict_below, aclk, aresetn, accept && cnt_lt_limit, !m_evict_valid, "evict below limit")
    `BSFI_ASSERT_NOW(a_evict_tag_zero, aclk, aresetn, m_valid && !m_evict_valid, m_evict_tag == '0, "stray evict tag")

endmodule

`default_nettype wire

FILE: sv/bsfi_cell.sv
// One cell of the sorted list: holds an entry, compares the offered key.
// Depends on bsfi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsfi_cell (
    input  wire  logic               aclk,
    input  wire  bsfi_pkg::entry_t   item,
    input  wire  bsfi_pkg::entry_t   left_entry,
    input  wire  logic               left_ge,
    input  wire  bsfi_pkg::cell_ctrl_t ctrl,
    output       bsfi_pkg::entry_t   held_entry,
    output       logic               ge
);

    bsfi_pkg::entry_t entry_reg;
    bsfi_pkg::entry_t entry_next;

    // free cells count as "key greater or equal", so ge stays monotone
    assign ge = !ctrl.occupied || (item.key <= entry_reg.key);
    assign held_entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.wr_en) begin
            if (left_ge) begin
                entry_next = left_entry;
            end else if (ge) begin
                entry_next = item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire
